// ===== hdl/fpp_pkg.sv =====
// Package: types and constants shared by the form-urlencoded pair parser modules.
`default_nettype none

package fpp_pkg;

  localparam int KLEN_W  = 5;
  localparam int VLEN_W  = 6;
  localparam int POS_W   = 6;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VAL     = 2'd1,
    KIND_KEY_OVF = 2'd2,
    KIND_VAL_OVF = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_WR_KEY  = 3'd0,
    OP_WR_VAL  = 3'd1,
    OP_ERR_KEY = 3'd2,
    OP_ERR_VAL = 3'd3,
    OP_FLUSH   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_request;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last_of_pair;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        data;
    logic [POS_W-1:0]  idx;
    logic [KLEN_W-1:0] klen;
    logic [VLEN_W-1:0] vlen;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/fpp_front.sv =====
// Front end: accepts request bytes, tracks pair and escape state, issues commands.
`default_nettype none

module fpp_front #(
  parameter int KEY_DEPTH   = 16,
  parameter int VALUE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fpp_pkg::in_t  in_item,
  input  wire logic          q_full,
  output logic               push,
  output fpp_pkg::cmd_t      cmd
);

  localparam logic [fpp_pkg::KLEN_W-1:0] KEY_LIM = fpp_pkg::KLEN_W'(KEY_DEPTH);
  localparam logic [fpp_pkg::VLEN_W-1:0] VAL_LIM = fpp_pkg::VLEN_W'(VALUE_DEPTH);

  logic [fpp_pkg::KLEN_W-1:0] klen_r, klen_nxt;
  logic [fpp_pkg::VLEN_W-1:0] vlen_r, vlen_nxt;
  logic                       in_value_r, in_value_nxt;
  logic [1:0]                 esc_r, esc_nxt;
  logic [3:0]                 part_r, part_nxt;
  logic                       skip_r, skip_nxt;

  logic       acc;
  logic [7:0] b;
  logic       e;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic       term;
  logic       store_req;
  logic [7:0] store_ch;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_item.byte_in;
  assign e        = in_item.end_of_request;
  assign {hex_ok, hex_d} = hex_dec(b);
  assign term = e || b == fpp_pkg::CH_AMP || b == fpp_pkg::CH_NUL ||
                b == fpp_pkg::CH_CR || b == fpp_pkg::CH_LF;

  always_comb begin
    klen_nxt     = klen_r;
    vlen_nxt     = vlen_r;
    in_value_nxt = in_value_r;
    esc_nxt      = esc_r;
    part_nxt     = part_r;
    skip_nxt     = skip_r;
    push         = 1'b0;
    cmd          = '0;
    store_req    = 1'b0;
    store_ch     = 8'h00;
    if (acc) begin
      if (skip_r) begin
        if (e) begin
          klen_nxt     = '0;
          vlen_nxt     = '0;
          in_value_nxt = 1'b0;
          esc_nxt      = 2'd0;
          part_nxt     = 4'd0;
          skip_nxt     = 1'b0;
        end
      end else if (esc_r != 2'd0 && !e) begin
        if (esc_r == 2'd1) begin
          esc_nxt  = hex_ok ? 2'd2 : 2'd3;
          part_nxt = hex_ok ? hex_d : 4'd0;
        end else begin
          esc_nxt   = 2'd0;
          part_nxt  = 4'd0;
          store_req = 1'b1;
          if (esc_r == 2'd2) store_ch = hex_ok ? {part_r, hex_d} : {4'd0, part_r};
        end
      end else if (term) begin
        if (in_value_r) begin
          push     = 1'b1;
          cmd.op   = fpp_pkg::OP_FLUSH;
          cmd.klen = klen_r;
          cmd.vlen = vlen_r;
        end
        klen_nxt     = '0;
        vlen_nxt     = '0;
        in_value_nxt = 1'b0;
        esc_nxt      = 2'd0;
        part_nxt     = 4'd0;
      end else if (b == fpp_pkg::CH_EQ && klen_r != '0) begin
        in_value_nxt = 1'b1;
      end else if (b < fpp_pkg::CH_SPACE || b >= fpp_pkg::CH_HIGH) begin
        // dropped
      end else if (b == fpp_pkg::CH_PCT) begin
        esc_nxt  = 2'd1;
        part_nxt = 4'd0;
      end else begin
        store_req = 1'b1;
        store_ch  = b;
      end

      if (store_req) begin
        push     = 1'b1;
        cmd.data = store_ch;
        if (!in_value_r) begin
          if (klen_r >= KEY_LIM) begin
            cmd.op   = fpp_pkg::OP_ERR_KEY;
            cmd.data = 8'h00;
            skip_nxt = 1'b1;
            esc_nxt  = 2'd0;
            part_nxt = 4'd0;
          end else begin
            cmd.op   = fpp_pkg::OP_WR_KEY;
            cmd.idx  = fpp_pkg::POS_W'(klen_r);
            klen_nxt = klen_r + 1'b1;
          end
        end else begin
          if (vlen_r >= VAL_LIM) begin
            cmd.op   = fpp_pkg::OP_ERR_VAL;
            cmd.data = 8'h00;
            skip_nxt = 1'b1;
            esc_nxt  = 2'd0;
            part_nxt = 4'd0;
          end else begin
            cmd.op   = fpp_pkg::OP_WR_VAL;
            cmd.idx  = fpp_pkg::POS_W'(vlen_r);
            vlen_nxt = vlen_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r     <= '0;
      vlen_r     <= '0;
      in_value_r <= 1'b0;
      esc_r      <= 2'd0;
      part_r     <= 4'd0;
      skip_r     <= 1'b0;
    end else begin
      klen_r     <= klen_nxt;
      vlen_r     <= vlen_nxt;
      in_value_r <= in_value_nxt;
      esc_r      <= esc_nxt;
      part_r     <= part_nxt;
      skip_r     <= skip_nxt;
    end
  end

  a_skip_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> esc_r == 2'd0)
    else $error("escape pending while skipping after error");

  a_value_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_r |-> klen_r != '0)
    else $error("value phase with empty key");

endmodule

`default_nettype wire

// ===== hdl/fpp_cmd_fifo.sv =====
// Command queue between the front end and the back end.
`default_nettype none

module fpp_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fpp_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output fpp_pkg::cmd_t      q_cmd
);

  fpp_pkg::cmd_t               slot_r [fpp_pkg::QDEPTH];
  logic [fpp_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [fpp_pkg::QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [fpp_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_pop;

  assign full    = cnt_r == fpp_pkg::QCNT_W'(fpp_pkg::QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_cmd   = slot_r[rptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + fpp_pkg::QCNT_W'(push) - fpp_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full command queue");

endmodule

`default_nettype wire

// ===== hdl/fpp_back.sv =====
// Back end: character stores, pair replay sequencer and result register.
`default_nettype none

module fpp_back #(
  parameter int KEY_DEPTH   = 16,
  parameter int VALUE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire fpp_pkg::cmd_t q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpp_pkg::out_t      out_item
);

  localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int VIDX_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

  logic [7:0] key_mem [KEY_DEPTH];
  logic [7:0] val_mem [VALUE_DEPTH];

  fpp_pkg::bk_state_t          state_r, state_nxt;
  logic [fpp_pkg::KLEN_W-1:0]  klen_r, klen_nxt;
  logic [fpp_pkg::POS_W-1:0]   total_r, total_nxt;
  logic [fpp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  fpp_pkg::out_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [7:0]                  key_rd_r, val_rd_r;
  logic                        sel_key_r;
  logic [fpp_pkg::POS_W-1:0]   voff;
  logic                        slot_free;
  logic                        load;
  logic                        key_we, val_we;
  logic                        last;

  assign slot_free = !out_valid_r || !out_stall;
  assign voff      = pos_r - fpp_pkg::POS_W'(klen_r);
  assign last      = pos_r + 1'b1 == total_r;
  assign key_we    = state_r == fpp_pkg::BK_IDLE && q_valid && q_cmd.op == fpp_pkg::OP_WR_KEY;
  assign val_we    = state_r == fpp_pkg::BK_IDLE && q_valid && q_cmd.op == fpp_pkg::OP_WR_VAL;

  always_comb begin
    state_nxt = state_r;
    klen_nxt  = klen_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    out_nxt   = out_r;
    pop       = 1'b0;
    load      = 1'b0;
    case (state_r)
      fpp_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            fpp_pkg::OP_WR_KEY, fpp_pkg::OP_WR_VAL: begin
              pop = 1'b1;
            end
            fpp_pkg::OP_ERR_KEY, fpp_pkg::OP_ERR_VAL: begin
              if (slot_free) begin
                pop  = 1'b1;
                load = 1'b1;
                out_nxt.kind = (q_cmd.op == fpp_pkg::OP_ERR_KEY) ?
                               fpp_pkg::KIND_KEY_OVF : fpp_pkg::KIND_VAL_OVF;
                out_nxt.char_out     = 8'h00;
                out_nxt.last_of_pair = 1'b1;
              end
            end
            fpp_pkg::OP_FLUSH: begin
              pop       = 1'b1;
              klen_nxt  = q_cmd.klen;
              total_nxt = fpp_pkg::POS_W'(q_cmd.klen) + q_cmd.vlen;
              pos_nxt   = '0;
              state_nxt = fpp_pkg::BK_READ;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      fpp_pkg::BK_READ: begin
        state_nxt = fpp_pkg::BK_SEND;
      end
      fpp_pkg::BK_SEND: begin
        if (slot_free) begin
          load = 1'b1;
          out_nxt.kind         = sel_key_r ? fpp_pkg::KIND_KEY : fpp_pkg::KIND_VAL;
          out_nxt.char_out     = sel_key_r ? key_rd_r : val_rd_r;
          out_nxt.last_of_pair = last;
          pos_nxt   = pos_r + 1'b1;
          state_nxt = last ? fpp_pkg::BK_IDLE : fpp_pkg::BK_READ;
        end
      end
      default: begin
        state_nxt = fpp_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[q_cmd.idx[KIDX_W-1:0]] <= q_cmd.data;
    if (val_we) val_mem[q_cmd.idx[VIDX_W-1:0]] <= q_cmd.data;
    key_rd_r  <= key_mem[pos_r[KIDX_W-1:0]];
    val_rd_r  <= val_mem[voff[VIDX_W-1:0]];
    sel_key_r <= pos_r < fpp_pkg::POS_W'(klen_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    klen_r  <= klen_nxt;
    total_r <= total_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_read_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fpp_pkg::BK_READ |=> state_r == fpp_pkg::BK_SEND)
    else $error("store read not followed by send");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpp_pkg::BK_READ || state_r == fpp_pkg::BK_SEND) |-> pos_r < total_r)
    else $error("replay position past pair length");

endmodule

`default_nettype wire

// ===== hdl/form_urlencoded_pair_parser.sv =====
// Top level of the form-urlencoded key/value pair parser.
// Throughput: one request byte per cycle while the command queue is not full; during a replay
//   the back end pops no command, and each result takes a store read, then a send, in turn.
// Path: a pair's terminator reaches its first result through the queue, BK_READ, BK_SEND and
//   the result register; an overflow byte through the queue and the result register only.
// Reset: synchronous active-low rst_n clears control state; character stores are not cleared.
`default_nettype none

module form_urlencoded_pair_parser #(
  parameter int KEY_DEPTH   = 16,
  parameter int VALUE_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fpp_pkg::in_t  in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpp_pkg::out_t      out_item
);

  logic          push;
  fpp_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          q_valid;
  fpp_pkg::cmd_t q_cmd;

  fpp_front #(
    .KEY_DEPTH   (KEY_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  fpp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  fpp_back #(
    .KEY_DEPTH   (KEY_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
